// File: hdl/pcdm_pkg.sv
`default_nettype none
package pcdm_pkg;

  localparam int TickW = 64;
  localparam int ErrW  = 48;
  localparam int AluW  = TickW + 1;

  // constant multiplier: microseconds per day
  localparam int MulW = 37;
  localparam logic [MulW-1:0] UsPerDay = 37'd86400000000;

  // numerator width of the drift division
  localparam int ProdW = TickW + MulW;
  localparam int CntW  = 7;

  localparam logic [ErrW-1:0] ErrMax = {1'b0, {(ErrW-1){1'b1}}};
  localparam logic [ErrW-1:0] ErrMin = {1'b1, {(ErrW-1){1'b0}}};

  localparam int MaxTestsDef       = 16;
  localparam int TicksPerSecondDef = 100000000;

  typedef enum logic [1:0] {
    REQ_PULSE = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_ROUNDS = 2'd1,
    CFG_TESTS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STD_A,
    ST_STD_B,
    ST_ELAP,
    ST_DIFF,
    ST_NEG,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_SAT,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] rounds;
    logic [4:0]  tests;
  } cfg_t;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic            run_done;
    logic [4:0]      tests_done;
    logic [15:0]     pulse_count;
    logic [ErrW-1:0] error_us_per_day;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/pcdm_addsub.sv
`default_nettype none
module pcdm_addsub
  import pcdm_pkg::*;
(
  input  wire alu_req_t   req_i,
  output logic [AluW-1:0] res_o
);

  logic [AluW-1:0] b_op;

  // with zero-extended operands, res_o[AluW-1] is the borrow of a subtract
  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign res_o = req_i.a + b_op + {{(AluW-1){1'b0}}, req_i.sub};

endmodule
`default_nettype wire

// File: hdl/pcdm_ctrl.sv
`default_nettype none
module pcdm_ctrl
  import pcdm_pkg::*;
#(
  parameter int MaxTests       = MaxTestsDef,
  parameter int TicksPerSecond = TicksPerSecondDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [TickW-1:0] now_ticks_i,
  input  wire cfg_t             cfg_i,
  input  wire logic             out_free_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam logic [29:0] Tps = 30'(TicksPerSecond);

  st_e state_q, state_d;

  logic             running_q, awaiting_q;
  logic [15:0]      pulses_q;
  logic [4:0]       rounds_done_q;
  logic [15:0]      lat_period_q, lat_rounds_q;
  logic [4:0]       lat_tests_q;
  logic [TickW-1:0] start_q, now_q, elap_q, std_q, rem_q;
  logic [31:0]      prod_q;
  logic [ProdW-1:0] p_q;
  logic [ErrW-1:0]  err_q;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q;

  alu_req_t        alu_req;
  logic [AluW-1:0] alu_res;
  logic            accept, cfg_ok, pulse_full, done;
  logic [15:0]     pulses_inc;
  logic [4:0]      rounds_inc;
  logic [61:0]     std_prod;
  logic [TickW-1:0] div_t;

  pcdm_addsub u_addsub (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign accept     = in_valid_i && in_ready_o;
  assign cfg_ok     = (cfg_i.period != '0) && (cfg_i.rounds != '0) && (cfg_i.tests != '0) &&
                      ({27'd0, cfg_i.tests} <= 32'(MaxTests));
  assign pulses_inc = pulses_q + 16'd1;
  assign pulse_full = pulses_inc >= lat_rounds_q;
  assign rounds_inc = rounds_done_q + 5'd1;
  assign done       = rounds_inc >= lat_tests_q;
  assign std_prod   = {30'd0, prod_q} * {32'd0, Tps};
  assign div_t      = {rem_q[TickW-2:0], p_q[ProdW-1]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_START && cfg_ok) begin
            state_d = ST_STD_A;
          end else if (req_type_i == REQ_PULSE && running_q && !awaiting_q && pulse_full) begin
            state_d = ST_ELAP;
          end
        end
      end
      ST_STD_A: state_d = ST_STD_B;
      ST_STD_B: state_d = ST_IDLE;
      ST_ELAP:  state_d = ST_DIFF;
      ST_DIFF:  state_d = alu_res[AluW-1] ? ST_NEG : ST_MUL;
      ST_NEG:   state_d = ST_MUL;
      ST_MUL:   if (cnt_q == '0) state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_SAT;
      ST_SAT:   state_d = ST_OUT;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and shared unit operands
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    alu_req     = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_ELAP: begin
        alu_req.a   = {1'b0, now_q};
        alu_req.b   = {1'b0, start_q};
        alu_req.sub = 1'b1;
      end
      ST_DIFF: begin
        alu_req.a   = {1'b0, elap_q};
        alu_req.b   = {1'b0, std_q};
        alu_req.sub = 1'b1;
      end
      ST_NEG: begin
        alu_req.a   = {1'b0, std_q};
        alu_req.b   = {1'b0, elap_q};
        alu_req.sub = 1'b1;
      end
      ST_MUL: begin
        alu_req.a = {1'b0, p_q[ProdW-1:MulW]};
        alu_req.b = {1'b0, elap_q};
      end
      ST_DIV: begin
        alu_req.a   = {1'b0, div_t};
        alu_req.b   = {1'b0, std_q};
        alu_req.sub = 1'b1;
      end
      ST_ROUND: begin
        // round half up: 2*rem >= standard
        alu_req.a   = {1'b0, rem_q[TickW-2:0], 1'b0};
        alu_req.b   = {1'b0, std_q};
        alu_req.sub = 1'b1;
      end
      ST_OUT: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o.run_done         = done;
  assign res_o.tests_done       = rounds_inc;
  assign res_o.pulse_count      = done ? pulses_q : 16'd0;
  assign res_o.error_us_per_day = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      running_q     <= 1'b0;
      awaiting_q    <= 1'b0;
      pulses_q      <= '0;
      rounds_done_q <= '0;
      start_q       <= '0;
      lat_period_q  <= '0;
      lat_rounds_q  <= '0;
      lat_tests_q   <= '0;
      cnt_q         <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_START: begin
                running_q <= cfg_ok;
                if (cfg_ok) begin
                  lat_period_q  <= cfg_i.period;
                  lat_rounds_q  <= cfg_i.rounds;
                  lat_tests_q   <= cfg_i.tests;
                  pulses_q      <= '0;
                  rounds_done_q <= '0;
                  start_q       <= '0;
                  awaiting_q    <= 1'b1;
                end
              end
              REQ_STOP: running_q <= 1'b0;
              REQ_PULSE: begin
                if (running_q) begin
                  if (awaiting_q) begin
                    start_q    <= now_ticks_i;
                    awaiting_q <= 1'b0;
                    pulses_q   <= '0;
                  end else begin
                    pulses_q <= pulses_inc;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIFF: begin
          if (!alu_res[AluW-1]) begin
            cnt_q <= CntW'(MulW - 1);
          end
        end
        ST_NEG: cnt_q <= CntW'(MulW - 1);
        ST_MUL: begin
          cnt_q <= (cnt_q == '0) ? CntW'(ProdW - 1) : cnt_q - 1'b1;
        end
        ST_DIV: cnt_q <= cnt_q - 1'b1;
        ST_OUT: begin
          if (out_free_i) begin
            rounds_done_q <= rounds_inc;
            if (done) begin
              running_q <= 1'b0;
            end else begin
              start_q  <= now_q;
              pulses_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:  now_q <= now_ticks_i;
      ST_STD_A: prod_q <= {16'd0, lat_period_q} * {16'd0, lat_rounds_q};
      ST_STD_B: std_q <= {2'b00, std_prod};
      ST_ELAP:  elap_q <= alu_res[TickW-1:0];
      ST_DIFF: begin
        neg_q <= alu_res[AluW-1];
        if (!alu_res[AluW-1]) begin
          elap_q <= alu_res[TickW-1:0];
          p_q    <= {{TickW{1'b0}}, UsPerDay};
          rem_q  <= '0;
        end
      end
      ST_NEG: begin
        elap_q <= alu_res[TickW-1:0];
        p_q    <= {{TickW{1'b0}}, UsPerDay};
        rem_q  <= '0;
      end
      ST_MUL: begin
        // shift-add, multiplier bits leave at the bottom
        if (p_q[0]) begin
          p_q <= {alu_res, p_q[MulW-1:1]};
        end else begin
          p_q <= {1'b0, p_q[ProdW-1:MulW], p_q[MulW-1:1]};
        end
      end
      ST_DIV: begin
        // restoring step: numerator leaves at the top, quotient enters at the bottom
        if (!alu_res[AluW-1]) begin
          rem_q <= alu_res[TickW-1:0];
          p_q   <= {p_q[ProdW-2:0], 1'b1};
        end else begin
          rem_q <= div_t;
          p_q   <= {p_q[ProdW-2:0], 1'b0};
        end
      end
      ST_ROUND: begin
        if (!alu_res[AluW-1]) begin
          p_q <= p_q + 1'b1;
        end
      end
      ST_SAT: begin
        if (!neg_q) begin
          err_q <= (p_q[ProdW-1:ErrW-1] != '0) ? ErrMax : p_q[ErrW-1:0];
        end else if ((p_q[ProdW-1:ErrW] != '0) || (p_q[ErrW-1] && (p_q[ErrW-2:0] != '0))) begin
          err_q <= ErrMin;
        end else begin
          err_q <= ~p_q[ErrW-1:0] + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < std_q)
    else $error("division remainder not below standard");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |=> (state_q == ST_DIV || state_q == ST_ROUND))
    else $error("division left early");

  a_res_std: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (std_q != '0 && running_q && !awaiting_q))
    else $error("result without an armed run");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.run_done) |-> res_o.pulse_count == lat_rounds_q)
    else $error("final pulse count mismatch");

endmodule
`default_nettype wire

// File: hdl/pps_clock_drift_meter.sv
// PPS clock drift meter.
// Input words (s_axis): tuser is the request (pulse, start, stop), tdata the
// local tick timestamp. A start with a valid config latches the config
// registers and arms a run; the first pulse sets the round start, and after
// rounds_per_test further pulses one result word leaves on m_axis with the
// drift in us/day. Config: cfg_we_i writes cfg_data_i into register
// cfg_idx_i (period, rounds, tests); a start picks the values up.
// A stop leaves tready high; a valid start first forms the nominal tick count
// in states STD_A and STD_B. A round-closing pulse goes through ELAP, DIFF,
// NEG (negative drift only), MUL, DIV, ROUND, SAT and OUT: 37 shift-add
// steps for the us/day multiply and 101 restoring divide steps, all through
// one 65-bit add/subtract unit. Its result word goes valid and tready rises
// in the same cycle. Other pulses leave tready high; tready stays low while
// a word is worked on. Results go to an output register; a stalled receiver
// holds the result there and the block keeps taking words until another
// result is ready. Reset clears the run state and the output valid flag;
// each config register resets to 1.
`default_nettype none
module pps_clock_drift_meter
  import pcdm_pkg::*;
#(
  parameter int MaxTests       = MaxTestsDef,
  parameter int TicksPerSecond = TicksPerSecondDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [TickW-1:0] s_axis_tdata,  // [63:0] now_ticks
  input  wire logic [1:0]       s_axis_tuser,  // [1:0] req_type
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [71:0]           m_axis_tdata,  // [4:0] tests_done, [20:5] pulse_count,
                                               // [68:21] error_us_per_day, rest 0
  output logic                  m_axis_tlast,  // run_done
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [15:0]      cfg_data_i
);

  cfg_t cfg_q;
  res_t res, out_q;
  logic res_valid, out_valid_q, out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= 16'd1;
      cfg_q.rounds <= 16'd1;
      cfg_q.tests  <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD: cfg_q.period <= cfg_data_i;
        CFG_ROUNDS: cfg_q.rounds <= cfg_data_i;
        CFG_TESTS:  cfg_q.tests  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  pcdm_ctrl #(
    .MaxTests       (MaxTests),
    .TicksPerSecond (TicksPerSecond)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .now_ticks_i (s_axis_tdata),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.run_done;
  assign m_axis_tdata  = {3'b000, out_q.error_us_per_day, out_q.pulse_count, out_q.tests_done};

endmodule
`default_nettype wire
